FILE: rtl/core/ifor_pkg.sv
// Shared constants and control types for the IP fragment order reverser.
package ifor_pkg;

  localparam int POOL_DEPTH = 32;
  localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int LIMIT_W    = 6;
  localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int HANDLE_W   = 16;
  localparam int LENGTH_W   = 14;
  localparam int DESC_W     = HANDLE_W + LENGTH_W;

  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] ETH_IPV6    = 16'h86DD;
  localparam logic [15:0] V4_MF       = 16'h2000;
  localparam logic [15:0] V4_OFF      = 16'h1FFF;
  localparam logic [7:0]  V6_FRAG_HDR = 8'd44;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  typedef struct packed {
    logic push;        // store the input descriptor on the stack
    logic load_in;     // put the input descriptor in the output register
    logic in_last;     // run_last for a loaded input descriptor
    logic rd_en;       // pop: read the top entry and decrement the count
    logic load_store;  // put the popped descriptor in the output register
  } ifor_cmd_t;

  typedef struct packed {
    logic is_frag;
    logic more;
    logic full;
    logic count_zero;
    logic out_free;
  } ifor_status_t;

endpackage

FILE: rtl/core/ifor_ctrl.sv
// Controller state machine: accepts beats and sequences the stack flush.
module ifor_ctrl import ifor_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ifor_status_t status,
  output ifor_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = !((state == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!status.is_frag || (status.more && status.full)) begin
            cmd.load_in = 1'b1;
            cmd.in_last = 1'b1;
          end else if (status.more) begin
            cmd.push = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            cmd.in_last = status.count_zero;
            if (!status.count_zero) state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_store = 1'b1;
          state_next     = status.count_zero ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/ifor_datapath.sv
// Datapath: header decode, descriptor stack, count, limit register and output register.
module ifor_datapath import ifor_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [LIMIT_W-1:0]  cfg_write_data,
  input  logic [15:0]         ethertype,
  input  logic [15:0]         ipv4_frag_word,
  input  logic [7:0]          ipv6_next_header,
  input  logic [15:0]         ipv6_frag_word,
  input  logic [HANDLE_W-1:0] packet_handle,
  input  logic [LENGTH_W-1:0] packet_length,
  input  ifor_cmd_t           cmd,
  output ifor_status_t        status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [LENGTH_W-1:0] out_length,
  output logic                from_store,
  output logic                run_last
);

  logic [DESC_W-1:0]  mem [POOL_DEPTH];
  logic [DESC_W-1:0]  rd_data;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_dec;
  logic [LIMIT_W-1:0] pool_limit;
  logic               is_v4_frag;
  logic               is_v6_frag;

  assign is_v4_frag = (ethertype == ETH_IPV4) && ((ipv4_frag_word & (V4_MF | V4_OFF)) != '0);
  assign is_v6_frag = (ethertype == ETH_IPV6) && (ipv6_next_header == V6_FRAG_HDR);
  assign count_dec  = count - CNT_W'(1);

  always_comb begin
    status.is_frag    = is_v4_frag || is_v6_frag;
    status.more       = is_v4_frag ? ((ipv4_frag_word & V4_MF) != '0) : ipv6_frag_word[0];
    // The effective limit is the smaller of the register and the stack depth.
    status.full       = (CMP_W'(count) >= CMP_W'(pool_limit)) ||
                        (count >= CNT_W'(POOL_DEPTH));
    status.count_zero = (count == '0);
    status.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      pool_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
    end else if (cmd.rd_en) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[ADDR_W-1:0]] <= {packet_handle, packet_length};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[count_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_in || cmd.load_store) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      out_handle <= packet_handle;
      out_length <= packet_length;
      from_store <= 1'b0;
      run_last   <= cmd.in_last;
    end else if (cmd.load_store) begin
      out_handle <= rd_data[DESC_W-1:LENGTH_W];
      out_length <= rd_data[LENGTH_W-1:0];
      from_store <= 1'b1;
      // The count has already been decremented for this entry.
      run_last   <= (count == '0);
    end
  end

endmodule

FILE: rtl/core/ip_fragment_order_reverser.sv
// Top level of the IP fragment order reverser: controller and datapath.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   ethertype .. packet_length
//   output    out        out_valid / out_stall out_handle, out_length, from_store, run_last
//   config    in         cfg_write_en          cfg_write_data (pool_limit)
//
// A beat is taken when the controller is idle and the output register is free; a push gives no result.
// A last fragment then flushes the stack one stored entry at a time: a registered memory
// read, then the load of the output register, per entry; new beats stall until it ends.
// Synchronous reset empties the stack count and sets pool_limit to 32; stack contents
// are not cleared. A stall on the output holds the output register and the flush.
module ip_fragment_order_reverser import ifor_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [LIMIT_W-1:0]  cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         ethertype,
  input  logic [15:0]         ipv4_frag_word,
  input  logic [7:0]          ipv6_next_header,
  input  logic [15:0]         ipv6_frag_word,
  input  logic [HANDLE_W-1:0] packet_handle,
  input  logic [LENGTH_W-1:0] packet_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [LENGTH_W-1:0] out_length,
  output logic                from_store,
  output logic                run_last
);

  ifor_cmd_t    cmd;
  ifor_status_t status;

  ifor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ifor_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .ethertype        (ethertype),
    .ipv4_frag_word   (ipv4_frag_word),
    .ipv6_next_header (ipv6_next_header),
    .ipv6_frag_word   (ipv6_frag_word),
    .packet_handle    (packet_handle),
    .packet_length    (packet_length),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_handle       (out_handle),
    .out_length       (out_length),
    .from_store       (from_store),
    .run_last         (run_last)
  );

endmodule
